>>> rtl/core/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants for the point to segment distance block.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

endpackage

>>> rtl/core/psd_in_if.sv
// ----------------------------------------------------------------------------
// psd_in_if
// Query channel: point and segment end points, valid/ready handshake.
// ----------------------------------------------------------------------------
interface psd_in_if #(
  parameter int CW = psd_pkg::COORD_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;

  modport source (output valid, point_x, point_y, start_x, start_y, end_x, end_y,
                  input ready);
  modport sink   (input valid, point_x, point_y, start_x, start_y, end_x, end_y,
                  output ready);
endinterface

>>> rtl/core/psd_out_if.sv
// ----------------------------------------------------------------------------
// psd_out_if
// Result channel: distance and degenerate flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface psd_out_if #(
  parameter int CW = psd_pkg::COORD_WIDTH_DEF
) ();
  logic          valid;
  logic          ready;
  logic [CW+1:0] distance;
  logic          degenerate;

  modport source (output valid, distance, degenerate, input ready);
  modport sink   (input valid, distance, degenerate, output ready);
endinterface

>>> rtl/core/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// Three stages: difference vectors, products, squared length and dot product.
// ----------------------------------------------------------------------------
module psd_front #(
  parameter int CW = psd_pkg::COORD_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [CW-1:0]    point_x,
  input  logic signed [CW-1:0]    point_y,
  input  logic signed [CW-1:0]    start_x,
  input  logic signed [CW-1:0]    start_y,
  input  logic signed [CW-1:0]    end_x,
  input  logic signed [CW-1:0]    end_y,
  output logic                    valid,
  output logic [2*CW+1:0]         len,
  output logic signed [2*CW+2:0]  dot,
  output logic signed [CW:0]      px,
  output logic signed [CW:0]      py,
  output logic signed [CW:0]      dx,
  output logic signed [CW:0]      dy,
  output logic                    degenerate
);
  import psd_pkg::*;

  localparam int PW = 2 * CW + 2;

  logic                 v1, v2;
  logic signed [CW:0]   px1, py1, dx1, dy1;
  logic signed [CW:0]   px2, py2, dx2, dy2;
  logic signed [PW-1:0] pxdx, pydy, dxdx, dydy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      v2    <= v1;
      valid <= v2;
    end
    if (en) begin
      px1  <= $signed({point_x[CW-1], point_x}) - $signed({start_x[CW-1], start_x});
      py1  <= $signed({point_y[CW-1], point_y}) - $signed({start_y[CW-1], start_y});
      dx1  <= $signed({end_x[CW-1], end_x}) - $signed({start_x[CW-1], start_x});
      dy1  <= $signed({end_y[CW-1], end_y}) - $signed({start_y[CW-1], start_y});
      pxdx <= PW'(px1 * dx1);
      pydy <= PW'(py1 * dy1);
      dxdx <= PW'(dx1 * dx1);
      dydy <= PW'(dy1 * dy1);
      px2  <= px1;
      py2  <= py1;
      dx2  <= dx1;
      dy2  <= dy1;
      len  <= $unsigned(dxdx) + $unsigned(dydy);
      dot  <= $signed({pxdx[PW-1], pxdx}) + $signed({pydy[PW-1], pydy});
      px   <= px2;
      py   <= py2;
      dx   <= dx2;
      dy   <= dy2;
      degenerate <= (dx2 == '0) && (dy2 == '0);
    end
  end

endmodule

>>> rtl/core/psd_div.sv
// ----------------------------------------------------------------------------
// psd_div
// Clamp and pipelined restoring division: t = dot / len, one bit per stage.
// ----------------------------------------------------------------------------
module psd_div #(
  parameter int CW = psd_pkg::COORD_WIDTH_DEF,
  parameter int FB = psd_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [2*CW+1:0]         in_len,
  input  logic signed [2*CW+2:0]  in_dot,
  input  logic signed [CW:0]      in_px,
  input  logic signed [CW:0]      in_py,
  input  logic signed [CW:0]      in_dx,
  input  logic signed [CW:0]      in_dy,
  input  logic                    in_deg,
  output logic                    valid,
  output logic [FB:0]             t,
  output logic signed [CW:0]      px,
  output logic signed [CW:0]      py,
  output logic signed [CW:0]      dx,
  output logic signed [CW:0]      dy,
  output logic                    degenerate
);
  import psd_pkg::*;

  localparam int LW = 2 * CW + 2;
  localparam int TW = FB + 1;

  logic               v     [0:FB];
  logic               fixed [0:FB];
  logic [LW-1:0]      rem   [0:FB];
  logic [LW-1:0]      lens  [0:FB];
  logic [TW-1:0]      ts    [0:FB];
  logic signed [CW:0] pxs   [0:FB];
  logic signed [CW:0] pys   [0:FB];
  logic signed [CW:0] dxs   [0:FB];
  logic signed [CW:0] dys   [0:FB];
  logic               degs  [0:FB];

  // Clamp: non-positive dot gives zero, dot at or past len gives one
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      lens[0] <= in_len;
      pxs[0]  <= in_px;
      pys[0]  <= in_py;
      dxs[0]  <= in_dx;
      dys[0]  <= in_dy;
      degs[0] <= in_deg;
      rem[0]  <= in_dot[LW-1:0];
      if (in_dot[LW] || in_dot == '0) begin
        fixed[0] <= 1'b1;
        ts[0]    <= '0;
      end else if (in_dot[LW-1:0] >= in_len) begin
        fixed[0] <= 1'b1;
        ts[0]    <= TW'(1) << FB;
      end else begin
        fixed[0] <= 1'b0;
        ts[0]    <= '0;
      end
    end
  end

  for (genvar k = 1; k <= FB; k++) begin : g_step
    logic [LW:0] shifted;
    logic        take;

    assign shifted = {rem[k-1], 1'b0};
    assign take    = shifted >= {1'b0, lens[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v[k-1];
      end
      if (en) begin
        lens[k]  <= lens[k-1];
        pxs[k]   <= pxs[k-1];
        pys[k]   <= pys[k-1];
        dxs[k]   <= dxs[k-1];
        dys[k]   <= dys[k-1];
        degs[k]  <= degs[k-1];
        fixed[k] <= fixed[k-1];
        if (fixed[k-1]) begin
          rem[k] <= rem[k-1];
          ts[k]  <= ts[k-1];
        end else begin
          rem[k] <= take ? LW'(shifted - {1'b0, lens[k-1]}) : LW'(shifted);
          ts[k]  <= {ts[k-1][TW-2:0], take};
        end
      end
    end
  end

  assign valid      = v[FB];
  assign t          = ts[FB];
  assign px         = pxs[FB];
  assign py         = pys[FB];
  assign dx         = dxs[FB];
  assign dy         = dys[FB];
  assign degenerate = degs[FB];

  a_t_max: assert property (@(posedge clk) disable iff (rst)
    v[FB] |-> ts[FB] <= (TW'(1) << FB))
    else $error("t above one");

  a_rem_below_len: assert property (@(posedge clk) disable iff (rst)
    (v[0] && !fixed[0]) |-> rem[0] < lens[0])
    else $error("partial remainder not below divisor");

  a_deg_zero_t: assert property (@(posedge clk) disable iff (rst)
    (v[FB] && degs[FB]) |-> ts[FB] == '0)
    else $error("degenerate segment with non-zero t");

endmodule

>>> rtl/core/psd_sqrt.sv
// ----------------------------------------------------------------------------
// psd_sqrt
// Offset along the segment, residual vector, squared length and a pipelined
// integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module psd_sqrt #(
  parameter int CW = psd_pkg::COORD_WIDTH_DEF,
  parameter int FB = psd_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [FB:0]        in_t,
  input  logic signed [CW:0] in_px,
  input  logic signed [CW:0] in_py,
  input  logic signed [CW:0] in_dx,
  input  logic signed [CW:0] in_dy,
  input  logic               in_deg,
  output logic               valid,
  output logic [CW+1:0]      distance,
  output logic               degenerate
);
  import psd_pkg::*;

  localparam int DW = CW + 2;
  localparam int MW = FB + CW + 3;
  localparam int QW = CW + 3;
  localparam int SW = 2 * QW;
  localparam int NW = 2 * DW;
  localparam int RW = DW + 3;

  logic                 v1, v2, v3;
  logic                 d1, d2, d3;
  logic signed [MW-1:0] mx, my;
  logic signed [CW:0]   px1, py1;
  logic signed [QW-1:0] qx, qy;
  logic signed [SW-1:0] sqx, sqy;

  logic          v    [0:DW];
  logic          degs [0:DW];
  logic [RW-1:0] rem  [0:DW];
  logic [DW-1:0] root [0:DW];
  logic [NW-1:0] nr   [0:DW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v[0] <= 1'b0;
    end else if (en) begin
      v1   <= in_valid;
      v2   <= v1;
      v3   <= v2;
      v[0] <= v3;
    end
    if (en) begin
      mx      <= MW'($signed({1'b0, in_t}) * in_dx);
      my      <= MW'($signed({1'b0, in_t}) * in_dy);
      px1     <= in_px;
      py1     <= in_py;
      d1      <= in_deg;
      // arithmetic shift floors toward minus infinity
      qx      <= QW'(px1) - QW'(mx >>> FB);
      qy      <= QW'(py1) - QW'(my >>> FB);
      d2      <= d1;
      sqx     <= SW'(qx * qx);
      sqy     <= SW'(qy * qy);
      d3      <= d2;
      nr[0]   <= NW'($unsigned(sqx) + $unsigned(sqy));
      rem[0]  <= '0;
      root[0] <= '0;
      degs[0] <= d3;
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_root
    logic [RW-1:0] shifted;
    logic [RW-1:0] trial;
    logic          take;

    assign shifted = {rem[k][RW-3:0], nr[k][NW-1:NW-2]};
    assign trial   = RW'({root[k], 2'b01});
    assign take    = shifted >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
      if (en) begin
        degs[k+1] <= degs[k];
        nr[k+1]   <= nr[k] << 2;
        rem[k+1]  <= take ? shifted - trial : shifted;
        root[k+1] <= {root[k][DW-2:0], take};
      end
    end
  end

  assign valid      = v[DW];
  assign distance   = root[DW];
  assign degenerate = degs[DW];

endmodule

>>> rtl/core/point_segment_distance.sv
// ----------------------------------------------------------------------------
// point_segment_distance
// Distance from a 2D point to a line segment, signed fixed point in,
// unsigned fixed point distance out, rounded down.
// ----------------------------------------------------------------------------
// Usage:
//   query  : one beat per point, carrying point, start and end coordinates.
//   result : one beat per query, in order: distance and degenerate flag
//            (set when start equals end; distance is then taken to start).
//   The pipeline has three front stages, one clamp stage and one stage
//   per bit of t in the divider, four stages for offset, residual,
//   squares and sum, and one stage per distance bit in the square root.
//   Throughput is one beat per cycle; a new query is taken every cycle
//   while the result side accepts or the last stage is empty.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds; nothing is dropped or repeated.
//   Reset clears every stage valid; no state is kept between queries.
// ----------------------------------------------------------------------------
module point_segment_distance #(
  parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = psd_pkg::FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  psd_in_if.sink      query,
  psd_out_if.source   result
);
  import psd_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic                   en;
  logic                   f_valid, f_deg;
  logic [2*CW+1:0]        f_len;
  logic signed [2*CW+2:0] f_dot;
  logic signed [CW:0]     f_px, f_py, f_dx, f_dy;
  logic                   d_valid, d_deg;
  logic [FRAC_BITS:0]     d_t;
  logic signed [CW:0]     d_px, d_py, d_dx, d_dy;

  // advance all stages unless a finished result is held
  assign en          = !result.valid || result.ready;
  assign query.ready = en;

  psd_front #(.CW(CW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (query.valid),
    .point_x    (query.point_x),
    .point_y    (query.point_y),
    .start_x    (query.start_x),
    .start_y    (query.start_y),
    .end_x      (query.end_x),
    .end_y      (query.end_y),
    .valid      (f_valid),
    .len        (f_len),
    .dot        (f_dot),
    .px         (f_px),
    .py         (f_py),
    .dx         (f_dx),
    .dy         (f_dy),
    .degenerate (f_deg)
  );

  psd_div #(.CW(CW), .FB(FRAC_BITS)) u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (f_valid),
    .in_len     (f_len),
    .in_dot     (f_dot),
    .in_px      (f_px),
    .in_py      (f_py),
    .in_dx      (f_dx),
    .in_dy      (f_dy),
    .in_deg     (f_deg),
    .valid      (d_valid),
    .t          (d_t),
    .px         (d_px),
    .py         (d_py),
    .dx         (d_dx),
    .dy         (d_dy),
    .degenerate (d_deg)
  );

  psd_sqrt #(.CW(CW), .FB(FRAC_BITS)) u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (d_valid),
    .in_t       (d_t),
    .in_px      (d_px),
    .in_py      (d_py),
    .in_dx      (d_dx),
    .in_dy      (d_dy),
    .in_deg     (d_deg),
    .valid      (result.valid),
    .distance   (result.distance),
    .degenerate (result.degenerate)
  );

endmodule
